// ===== rtl/gls_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Levinson solver.
// No dependencies; every other file of the block but gls_ram imports this package.
package gls_pkg;

  localparam int MAX_TAPS_DEF = 32;
  localparam int TAPS_W = 6;
  localparam int CORR_W = 32;
  localparam int COEF_W = 32;
  localparam int TAP_W = 5;
  localparam int ACC_W = 48;
  localparam int PROD_W = 64;
  localparam int FRAC_W = 24;

  typedef struct packed {
    logic [TAPS_W-1:0]        lag;
    logic signed [CORR_W-1:0] auto_corr;
    logic signed [CORR_W-1:0] cross_corr;
  } in_word_t;

  typedef struct packed {
    logic [TAP_W-1:0]         tap;
    logic signed [COEF_W-1:0] coefficient;
    logic                     last;
    logic                     status;
  } out_word_t;

  typedef enum logic [4:0] {
    S_IDLE, S_E0_RD, S_E0, S_ACC_RD, S_ACC, S_DOT_RD, S_DOT_M1, S_DOT_M2, S_DOT_A2,
    S_DIVK, S_DIVK_W, S_DIVB, S_DIVB_W, S_UPD_RD1, S_UPD_RD2, S_UPD_M1, S_UPD_M2,
    S_UPD_WR, S_E_SQ, S_E_MUL, S_E_UPD, S_OUT_RD, S_OUT
  } ctl_state_t;

  typedef enum logic [4:0] {
    OP_IDLE, OP_E0_RD, OP_E0, OP_ACC_RD, OP_ACC, OP_DOT_RD, OP_DOT_M1, OP_DOT_M2,
    OP_DOT_A2, OP_DIVK, OP_DIVK_W, OP_DIVB, OP_DIVB_W, OP_UPD_RD1, OP_UPD_RD2,
    OP_UPD_M1, OP_UPD_M2, OP_UPD_WR, OP_E_SQ, OP_E_MUL, OP_E_UPD, OP_OUT_RD, OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   bank;
    logic   wr_auto;
    logic   wr_cross;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_stat_t;

  function automatic logic signed [PROD_W-1:0] rnd_q24(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] half;
    half = PROD_W'(64'sd1 <<< (FRAC_W - 1));
    rnd_q24 = (v + half) >>> FRAC_W;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
    if ((&v[PROD_W-1:31]) || !(|v[PROD_W-1:31])) begin
      sat32 = v[31:0];
    end else if (v[PROD_W-1]) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = 32'sh7FFF_FFFF;
    end
  endfunction

endpackage

// ===== rtl/generalized_levinson_solver.sv =====
// Levinson solver top level. Loading accepts one word per cycle (taps+1 words).
// The solve then runs on one shared multiplier and a bit-serial divider.
// Results leave one word at a time; the next load starts after the last.
// Synchronous reset returns to idle with taps set to 32 and the load count cleared.
module generalized_levinson_solver #(
  parameter int MAX_TAPS = gls_pkg::MAX_TAPS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [gls_pkg::TAPS_W-1:0] cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  gls_pkg::in_word_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output gls_pkg::out_word_t         out_data
);
  import gls_pkg::*;

  localparam int CW = $clog2(MAX_TAPS + 1);

  dp_cmd_t       cmd;
  dp_stat_t      stat;
  logic [CW-1:0] m, i, n;

  gls_ctrl #(.MAX_TAPS(MAX_TAPS)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .lag(in_data.lag),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data), .out_valid(out_valid),
    .out_ready(out_ready), .cmd(cmd), .stat(stat), .m(m), .i(i), .n(n)
  );

  gls_datapath #(.MAX_TAPS(MAX_TAPS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .m(m), .i(i), .n(n), .in_data(in_data),
    .out_data(out_data), .stat(stat)
  );

endmodule

// ===== rtl/gls_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/gls_div.sv =====
// Bit-serial divider giving a rounded, saturated Q8.24 quotient.
// Depends on gls_pkg.
module gls_div (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic signed [gls_pkg::ACC_W-1:0] num,
  input  logic signed [31:0]              den,
  output logic                            done,
  output logic signed [31:0]              quo
);
  import gls_pkg::*;

  logic              busy;
  logic              fin;
  logic              neg;
  logic [4:0]        cnt;
  logic [31:0]       rem;
  logic [31:0]       q;
  logic [31:0]       dreg;
  logic [ACC_W-1:0]  mag;
  logic [31:0]       dd;
  logic              num_big;
  logic [63:0]       nn;
  logic [32:0]       trial;
  logic              ge;
  logic [32:0]       diff;
  logic signed [31:0] q_final;

  always_comb begin
    mag = num[ACC_W-1] ? ACC_W'(-num) : num;
    dd = den;
    num_big = 64'(mag) >= (64'(dd) << 7);
    nn = (64'(mag) << FRAC_W) + 64'(dd >> 1);
    trial = {rem, q[31]};
    ge = trial >= {1'b0, dreg};
    diff = trial - {1'b0, dreg};
    if (neg) begin
      q_final = (q > 32'h8000_0000) ? 32'sh8000_0000 : -$signed(q);
    end else begin
      q_final = q[31] ? 32'sh7FFF_FFFF : $signed(q);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      fin <= 1'b0;
      if (start) begin
        neg <= num[ACC_W-1];
        dreg <= dd;
        if (dd == 32'd0) begin
          quo <= '0;
          done <= 1'b1;
        end else if (num_big) begin
          quo <= num[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
          done <= 1'b1;
        end else begin
          rem <= nn[63:32];
          q <= nn[31:0];
          cnt <= '0;
          busy <= 1'b1;
        end
      end else if (busy) begin
        rem <= ge ? diff[31:0] : trial[31:0];
        q <= {q[30:0], ge};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        quo <= q_final;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/gls_datapath.sv =====
// Datapath: correlation and coefficient stores, multiplier, accumulators, error power.
// Depends on gls_pkg, gls_ram and gls_div.
module gls_datapath #(
  parameter int MAX_TAPS = gls_pkg::MAX_TAPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  gls_pkg::dp_cmd_t                 cmd,
  input  logic [$clog2(MAX_TAPS+1)-1:0]    m,
  input  logic [$clog2(MAX_TAPS+1)-1:0]    i,
  input  logic [$clog2(MAX_TAPS+1)-1:0]    n,
  input  gls_pkg::in_word_t                in_data,
  output gls_pkg::out_word_t               out_data,
  output gls_pkg::dp_stat_t                stat
);
  import gls_pkg::*;

  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam int IW = $clog2(MAX_TAPS);

  logic signed [ACC_W-1:0]  acc1;
  logic signed [ACC_W-1:0]  acc2;
  logic signed [PROD_W-1:0] prod;
  logic signed [31:0]       pj;
  logic signed [31:0]       k;
  logic signed [31:0]       bm;
  logic signed [31:0]       e;
  logic                     bad;

  logic [31:0]   a_rd, c_rd, p_rd, w_rd;
  logic [CW-1:0] a_raddr;
  logic [IW:0]   p_raddr, p_waddr;
  logic [IW-1:0] w_waddr;
  logic          p_we, w_we;
  logic [31:0]   p_wdata, w_wdata;

  logic signed [PROD_W-1:0] term;
  logic signed [PROD_W-1:0] fac_w;
  logic signed [25:0]       fac;
  logic signed [31:0]       p_new, w_new;
  logic                     k_big;
  logic signed [ACC_W-1:0]  div_num;
  logic                     div_start;
  logic                     div_done;
  logic signed [31:0]       div_quo;

  always_comb begin
    unique case (cmd.op)
      OP_E0_RD: a_raddr = '0;
      OP_ACC_RD: a_raddr = m + CW'(1);
      default: a_raddr = m - i;
    endcase
    p_raddr = {cmd.bank, (cmd.op == OP_UPD_RD1) ? IW'(m - i - CW'(1)) : IW'(i)};
    term = rnd_q24(prod);
    p_new = sat32(PROD_W'($signed(p_rd)) + term);
    w_new = sat32(PROD_W'($signed(w_rd)) + term);
    p_we = (cmd.op == OP_UPD_M2) || (cmd.op == OP_E_SQ);
    w_we = (cmd.op == OP_UPD_WR) || (cmd.op == OP_E_SQ);
    p_waddr = {~cmd.bank, (cmd.op == OP_E_SQ) ? IW'(m) : IW'(i)};
    w_waddr = (cmd.op == OP_E_SQ) ? IW'(m) : IW'(i);
    p_wdata = (cmd.op == OP_E_SQ) ? k : p_new;
    w_wdata = (cmd.op == OP_E_SQ) ? bm : w_new;
    fac_w = (PROD_W'(64'sd1) <<< FRAC_W) - term;
    fac = fac_w[25:0];
    k_big = (k >= 32'sd16777216) || (k <= -32'sd16777216);
    div_num = (cmd.op == OP_DIVK) ? -acc1 : acc2;
    div_start = (cmd.op == OP_DIVK) || (cmd.op == OP_DIVB);
  end

  gls_ram #(.WIDTH(32), .DEPTH(MAX_TAPS + 1)) u_auto (
    .clk(clk), .we(cmd.wr_auto), .waddr(CW'(in_data.lag)), .wdata(in_data.auto_corr),
    .raddr(a_raddr), .rdata(a_rd)
  );

  gls_ram #(.WIDTH(32), .DEPTH(MAX_TAPS)) u_cross (
    .clk(clk), .we(cmd.wr_cross), .waddr(IW'(in_data.lag)), .wdata(in_data.cross_corr),
    .raddr(IW'(m)), .rdata(c_rd)
  );

  gls_ram #(.WIDTH(32), .DEPTH(2 * MAX_TAPS)) u_pred (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rd)
  );

  gls_ram #(.WIDTH(32), .DEPTH(MAX_TAPS)) u_wien (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr(IW'(i)), .rdata(w_rd)
  );

  gls_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(e),
    .done(div_done), .quo(div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      e <= '0;
      bad <= 1'b0;
    end else begin
      case (cmd.op)
        OP_E0: begin
          e <= ($signed(a_rd) > 0) ? $signed(a_rd) : '0;
          bad <= !($signed(a_rd) > 0);
        end
        OP_ACC: begin
          acc1 <= ACC_W'($signed(a_rd));
          acc2 <= ACC_W'($signed(c_rd));
        end
        OP_DOT_M1: prod <= $signed(p_rd) * $signed(a_rd);
        OP_DOT_M2: begin
          acc1 <= acc1 + ACC_W'(term);
          prod <= $signed(w_rd) * $signed(a_rd);
        end
        OP_DOT_A2: acc2 <= acc2 - ACC_W'(term);
        OP_DIVK, OP_DIVB: begin
          if (e == 32'sd0) begin
            bad <= 1'b1;
          end
        end
        OP_DIVK_W: begin
          if (div_done) begin
            k <= div_quo;
          end
        end
        OP_DIVB_W: begin
          if (div_done) begin
            bm <= div_quo;
          end
        end
        OP_UPD_RD2: pj <= $signed(p_rd);
        OP_UPD_M1: prod <= k * pj;
        OP_UPD_M2: prod <= bm * pj;
        OP_E_SQ: prod <= k * k;
        OP_E_MUL: prod <= e * fac;
        OP_E_UPD: begin
          if (e != 32'sd0) begin
            if (k_big || term <= 0) begin
              e <= '0;
              bad <= 1'b1;
            end else begin
              e <= term[31:0];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    out_data.tap = TAP_W'(i);
    out_data.coefficient = $signed(w_rd);
    out_data.last = (i + CW'(1) == n);
    out_data.status = bad;
    stat.div_done = div_done;
  end

  assert property (@(posedge clk) disable iff (rst) !e[31])
    else $error("error power has gone negative");
  assert property (@(posedge clk) disable iff (rst) (cmd.op == OP_E0) |=> (bad == (e == 0)))
    else $error("initial error power and singular flag disagree");
  assert property (@(posedge clk) disable iff (rst) div_done |=> !div_done)
    else $error("divider completion held for more than one cycle");

endmodule

// ===== rtl/gls_ctrl.sv =====
// Controller: load sequencing, recursion order and tap counters, result hand-off.
// Depends on gls_pkg.
module gls_ctrl #(
  parameter int MAX_TAPS = gls_pkg::MAX_TAPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [gls_pkg::TAPS_W-1:0]        lag,
  input  logic                              cfg_wr_en,
  input  logic [gls_pkg::TAPS_W-1:0]        cfg_wr_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gls_pkg::dp_cmd_t                  cmd,
  input  gls_pkg::dp_stat_t                 stat,
  output logic [$clog2(MAX_TAPS+1)-1:0]     m,
  output logic [$clog2(MAX_TAPS+1)-1:0]     i,
  output logic [$clog2(MAX_TAPS+1)-1:0]     n
);
  import gls_pkg::*;

  localparam int CW = $clog2(MAX_TAPS + 1);
  localparam int TW = (CW > TAPS_W) ? CW : TAPS_W;

  ctl_state_t        state, state_next;
  logic [CW-1:0]     lc;
  logic [TAPS_W-1:0] taps;
  logic              bank;
  logic [TW-1:0]     lag_x, lc_x, n_x;
  logic              accept, item_ok, load_done, i_last;

  always_comb begin
    if (taps == '0) begin
      n = CW'(1);
    end else if (TW'(taps) > TW'(MAX_TAPS)) begin
      n = CW'(MAX_TAPS);
    end else begin
      n = CW'(taps);
    end
    lag_x = TW'(lag);
    lc_x = (lag == '0) ? '0 : TW'(lc);
    n_x = TW'(n);
    accept = in_valid && in_ready;
    item_ok = (lag_x == lc_x) && (lag_x <= n_x);
    load_done = item_ok && (lag_x == n_x);
    i_last = (i + CW'(1) == m);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept && load_done) state_next = S_E0_RD;
      S_E0_RD: state_next = S_E0;
      S_E0: state_next = S_ACC_RD;
      S_ACC_RD: state_next = S_ACC;
      S_ACC: state_next = (m == '0) ? S_DIVK : S_DOT_RD;
      S_DOT_RD: state_next = S_DOT_M1;
      S_DOT_M1: state_next = S_DOT_M2;
      S_DOT_M2: state_next = S_DOT_A2;
      S_DOT_A2: state_next = i_last ? S_DIVK : S_DOT_RD;
      S_DIVK: state_next = S_DIVK_W;
      S_DIVK_W: if (stat.div_done) state_next = S_DIVB;
      S_DIVB: state_next = S_DIVB_W;
      S_DIVB_W: begin
        if (stat.div_done) state_next = (m == '0) ? S_E_SQ : S_UPD_RD1;
      end
      S_UPD_RD1: state_next = S_UPD_RD2;
      S_UPD_RD2: state_next = S_UPD_M1;
      S_UPD_M1: state_next = S_UPD_M2;
      S_UPD_M2: state_next = S_UPD_WR;
      S_UPD_WR: state_next = i_last ? S_E_SQ : S_UPD_RD1;
      S_E_SQ: state_next = S_E_MUL;
      S_E_MUL: state_next = S_E_UPD;
      S_E_UPD: state_next = (m + CW'(1) == n) ? S_OUT_RD : S_ACC_RD;
      S_OUT_RD: state_next = S_OUT;
      S_OUT: begin
        if (out_ready) state_next = (i + CW'(1) == n) ? S_IDLE : S_OUT_RD;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    out_valid = (state == S_OUT);
    cmd.bank = bank;
    cmd.wr_auto = accept && item_ok;
    cmd.wr_cross = accept && item_ok && (lag_x < n_x);
    unique case (state)
      S_IDLE: cmd.op = OP_IDLE;
      S_E0_RD: cmd.op = OP_E0_RD;
      S_E0: cmd.op = OP_E0;
      S_ACC_RD: cmd.op = OP_ACC_RD;
      S_ACC: cmd.op = OP_ACC;
      S_DOT_RD: cmd.op = OP_DOT_RD;
      S_DOT_M1: cmd.op = OP_DOT_M1;
      S_DOT_M2: cmd.op = OP_DOT_M2;
      S_DOT_A2: cmd.op = OP_DOT_A2;
      S_DIVK: cmd.op = OP_DIVK;
      S_DIVK_W: cmd.op = OP_DIVK_W;
      S_DIVB: cmd.op = OP_DIVB;
      S_DIVB_W: cmd.op = OP_DIVB_W;
      S_UPD_RD1: cmd.op = OP_UPD_RD1;
      S_UPD_RD2: cmd.op = OP_UPD_RD2;
      S_UPD_M1: cmd.op = OP_UPD_M1;
      S_UPD_M2: cmd.op = OP_UPD_M2;
      S_UPD_WR: cmd.op = OP_UPD_WR;
      S_E_SQ: cmd.op = OP_E_SQ;
      S_E_MUL: cmd.op = OP_E_MUL;
      S_E_UPD: cmd.op = OP_E_UPD;
      S_OUT_RD: cmd.op = OP_OUT_RD;
      S_OUT: cmd.op = OP_OUT;
      default: cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lc <= '0;
      taps <= TAPS_W'(32);
      bank <= 1'b0;
      m <= '0;
      i <= '0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        taps <= cfg_wr_data;
        lc <= '0;
      end else if (accept && item_ok) begin
        lc <= load_done ? '0 : CW'(lag_x + TW'(1));
      end
      case (state)
        S_IDLE: begin
          m <= '0;
          i <= '0;
          bank <= 1'b0;
        end
        S_DOT_A2, S_UPD_WR: i <= i_last ? '0 : i + CW'(1);
        S_E_UPD: begin
          m <= m + CW'(1);
          i <= '0;
          bank <= ~bank;
        end
        S_OUT: if (out_ready) i <= i + CW'(1);
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_ready |-> !out_valid)
    else $error("input taken while a result is offered");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DIVK_W && !stat.div_done) |=> (state == S_DIVK_W))
    else $error("left the division wait before the quotient arrived");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_ready && (i + CW'(1) == n)) |=> (state == S_IDLE))
    else $error("final word taken but the controller did not return to idle");
  assert property (@(posedge clk) disable iff (rst) (state == S_ACC) |-> (m < n))
    else $error("recursion order beyond the filter length");

endmodule
